### design/gns_pkg.sv
package gns_pkg;

    // Sample format and register reset values.
    localparam int FRAC_BITS = 16;
    localparam logic [31:0] SIGMA_RESET =
        (FRAC_BITS >= 32) ? 32'hFFFF_FFFF : 32'(64'd1 << FRAC_BITS);

    // Configuration register indexes.
    localparam logic [1:0] REG_MEAN  = 2'd0;
    localparam logic [1:0] REG_SIGMA = 2'd1;

    // Arithmetic constants.
    localparam int          ZQ       = 24;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] INVA_LO  = 32'(64'd29217464599);
    localparam int          INVA_HI  = 6;
    localparam logic [31:0] K_Q24    = 32'd72657874;
    localparam logic [30:0] P_LIMIT  = 31'(127 << ZQ);

    // Pipeline geometry.
    localparam int LOG_STEPS  = ZQ;
    localparam int SQRT_STEPS = 32;
    localparam int IDX_SQ0    = 3;
    localparam int IDX_L      = IDX_SQ0 + LOG_STEPS;
    localparam int IDX_M      = IDX_L + 1;
    localparam int IDX_T      = IDX_M + 1;
    localparam int IDX_X      = IDX_T + 1;
    localparam int IDX_Q      = IDX_X + 1;
    localparam int IDX_R1     = IDX_Q + 1;
    localparam int IDX_D      = IDX_R1 + SQRT_STEPS;
    localparam int IDX_R2     = IDX_D + 1;
    localparam int IDX_S      = IDX_R2 + SQRT_STEPS;
    localparam int IDX_RND    = IDX_S + 1;
    localparam int DEPTH      = IDX_RND + 1;
    localparam int OUT_LAT    = DEPTH + 1;

    // Side information that travels with each request.
    typedef struct packed {
        logic        neg;
        logic        tail;
        logic        last;
        logic [31:0] offset;
    } t_side;

endpackage

### design/gaussian_noise_sampler_core.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------
// request  | in        | i_start, o_busy    | i_uniform_word, i_offset_value, i_last_in
// result   | out       | o_valid (strobe)   | o_noisy_sample, o_saturated, o_last_out
// config   | in        | i_cfg_wr_en        | i_cfg_index, i_cfg_wdata
//
// A new request is taken every cycle; o_busy stays low.
// Each result is registered on the result ports at the end of the pipeline, whose
// depth is set by the 24 squaring steps of the two logarithms and the two
// 32-step square-root chains.
// Reset is synchronous; it clears the valid bits and the mean and sets sigma to its reset value.
// The receiver cannot stall; nothing in the pipeline ever waits.
module gaussian_noise_sampler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_uniform_word,
    input  logic signed [31:0] i_offset_value,
    input  logic        i_last_in,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic signed [31:0] o_noisy_sample,
    output logic        o_saturated,
    output logic        o_last_out
);

    // Configuration registers.
    logic [31:0] r_mean;
    logic [31:0] r_sigma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_sigma <= gns_pkg::SIGMA_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == gns_pkg::REG_MEAN) begin
                r_mean <= i_cfg_wdata;
            end
            if (i_cfg_index == gns_pkg::REG_SIGMA) begin
                r_sigma <= i_cfg_wdata;
            end
        end
    end

    assign o_busy = 1'b0;

    // Valid bits and side information, one entry per stage.
    logic                  r_vld [0:gns_pkg::DEPTH-1];
    gns_pkg::t_side        r_sb  [0:gns_pkg::DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gns_pkg::DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_start;
            for (int i = 1; i < gns_pkg::DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0].neg    <= ~i_uniform_word[63];
        r_sb[0].tail   <= (i_uniform_word == '0) || (i_uniform_word == '1);
        r_sb[0].last   <= i_last_in;
        r_sb[0].offset <= i_offset_value;
        for (int i = 1; i < gns_pkg::DEPTH; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    // Stage 0: fold the word to a = |2U - (2^64-1)|, then e = 1 - a and w.
    logic [63:0] n_a;
    logic [63:0] r_e0, r_w0;

    assign n_a = i_uniform_word[63] ? {i_uniform_word[62:0], 1'b1}
                                    : ~{i_uniform_word[62:0], 1'b0};

    always_ff @(posedge i_clk) begin
        r_e0 <= (~n_a) + 64'd1;
        r_w0 <= {1'b1, 63'd0} + {1'b0, n_a[63:1]};
    end

    // Stage 1: leading-one position of both operands.
    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] k;
        k = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

    logic [63:0] r_e1, r_w1;
    logic [5:0]  r_ke1, r_kw1;

    always_ff @(posedge i_clk) begin
        r_e1  <= r_e0;
        r_w1  <= r_w0;
        r_ke1 <= lead_one(r_e0);
        r_kw1 <= lead_one(r_w0);
    end

    // Stage 2: normalize to a Q1.31 mantissa.
    logic [63:0] n_en, n_wn;
    logic [31:0] r_ye [0:gns_pkg::LOG_STEPS];
    logic [31:0] r_yw [0:gns_pkg::LOG_STEPS];
    logic [gns_pkg::ZQ-1:0] r_fe [0:gns_pkg::LOG_STEPS];
    logic [gns_pkg::ZQ-1:0] r_fw [0:gns_pkg::LOG_STEPS];
    logic [5:0]  r_ke [0:gns_pkg::LOG_STEPS];
    logic [5:0]  r_kw [0:gns_pkg::LOG_STEPS];

    assign n_en = r_e1 << (6'd63 - r_ke1);
    assign n_wn = r_w1 << (6'd63 - r_kw1);

    always_ff @(posedge i_clk) begin
        r_ye[0] <= n_en[63:32];
        r_yw[0] <= n_wn[63:32];
        r_fe[0] <= '0;
        r_fw[0] <= '0;
        r_ke[0] <= r_ke1;
        r_kw[0] <= r_kw1;
    end

    // Squaring steps: one fraction bit of each logarithm per stage.
    for (genvar g = 0; g < gns_pkg::LOG_STEPS; g++) begin : g_log
        logic [63:0] sq_e, sq_w;
        logic [32:0] t_e, t_w;

        assign sq_e = 64'(r_ye[g]) * 64'(r_ye[g]);
        assign sq_w = 64'(r_yw[g]) * 64'(r_yw[g]);
        assign t_e  = sq_e[63:31];
        assign t_w  = sq_w[63:31];

        always_ff @(posedge i_clk) begin
            r_ye[g+1] <= t_e[32] ? t_e[32:1] : t_e[31:0];
            r_yw[g+1] <= t_w[32] ? t_w[32:1] : t_w[31:0];
            r_fe[g+1] <= {r_fe[g][gns_pkg::ZQ-2:0], t_e[32]};
            r_fw[g+1] <= {r_fw[g][gns_pkg::ZQ-2:0], t_w[32]};
            r_ke[g+1] <= r_ke[g];
            r_kw[g+1] <= r_kw[g];
        end
    end

    // P = 127 - log2(e) - log2(w), clamped at zero.
    logic [30:0] n_l2;
    logic [30:0] r_p;

    assign n_l2 = {1'b0, r_ke[gns_pkg::LOG_STEPS], r_fe[gns_pkg::LOG_STEPS]}
                + {1'b0, r_kw[gns_pkg::LOG_STEPS], r_fw[gns_pkg::LOG_STEPS]};

    always_ff @(posedge i_clk) begin
        r_p <= (n_l2 >= gns_pkg::P_LIMIT) ? '0 : gns_pkg::P_LIMIT - n_l2;
    end

    // Lm = P * ln2.
    logic [62:0] n_plm;
    logic [30:0] r_lm;

    assign n_plm = 63'(r_p) * 63'(gns_pkg::LN2_Q32);

    always_ff @(posedge i_clk) begin
        r_lm <= n_plm[62:32];
    end

    // t1 = 2/(pi*a) - Lm/2 and its magnitude.
    logic signed [31:0] n_t1;
    logic signed [31:0] r_t1t;
    logic [30:0]        r_at1;
    logic [30:0]        r_lmt;

    assign n_t1 = $signed(gns_pkg::K_Q24) - $signed({2'b00, r_lm[30:1]});

    always_ff @(posedge i_clk) begin
        r_t1t <= n_t1;
        r_at1 <= n_t1[31] ? 31'(-n_t1) : n_t1[30:0];
        r_lmt <= r_lm;
    end

    // t1^2 and Lm / a.
    logic [61:0] n_sq;
    logic [62:0] n_llo;
    logic [33:0] n_lhi;
    logic [37:0] r_t1sq;
    logic [33:0] r_mlm;
    logic signed [31:0] r_t1x;

    assign n_sq  = 62'(r_at1) * 62'(r_at1);
    assign n_llo = 63'(r_lmt) * 63'(gns_pkg::INVA_LO);
    assign n_lhi = 34'(r_lmt) * 34'(gns_pkg::INVA_HI);

    always_ff @(posedge i_clk) begin
        r_t1sq <= n_sq[61:24];
        r_mlm  <= n_lhi + 34'(n_llo[62:32]);
        r_t1x  <= r_t1t;
    end

    // q = t1^2 + Lm/a, radicand q * 2^24.
    logic [38:0] n_q;
    logic [63:0] r_v1 [0:gns_pkg::SQRT_STEPS];
    logic [63:0] r_r1 [0:gns_pkg::SQRT_STEPS];
    logic signed [31:0] r_t1s [0:gns_pkg::SQRT_STEPS];

    assign n_q = 39'(r_t1sq) + 39'(r_mlm);

    always_ff @(posedge i_clk) begin
        r_v1[0]  <= {n_q, 25'd0} >> 1;
        r_r1[0]  <= '0;
        r_t1s[0] <= r_t1x;
    end

    // First square root, one result bit per stage.
    for (genvar g = 0; g < gns_pkg::SQRT_STEPS; g++) begin : g_sqrt1
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] trial;

        assign trial = r_r1[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (r_v1[g] >= trial) begin
                r_v1[g+1] <= r_v1[g] - trial;
                r_r1[g+1] <= (r_r1[g] >> 1) + BIT;
            end else begin
                r_v1[g+1] <= r_v1[g];
                r_r1[g+1] <= r_r1[g] >> 1;
            end
            r_t1s[g+1] <= r_t1s[g];
        end
    end

    // d = S - t1, clamped at zero, radicand 2 * d * 2^24.
    logic signed [33:0] n_d;
    logic [38:0]        n_dc;
    logic [63:0] r_v2 [0:gns_pkg::SQRT_STEPS];
    logic [63:0] r_r2 [0:gns_pkg::SQRT_STEPS];

    assign n_d  = $signed({2'b00, r_r1[gns_pkg::SQRT_STEPS][31:0]})
                - 34'(r_t1s[gns_pkg::SQRT_STEPS]);
    assign n_dc = n_d[33] ? '0 : 39'(n_d[32:0]);

    always_ff @(posedge i_clk) begin
        r_v2[0] <= {n_dc, 25'd0};
        r_r2[0] <= '0;
    end

    // Second square root gives |z| in Q24.
    for (genvar g = 0; g < gns_pkg::SQRT_STEPS; g++) begin : g_sqrt2
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] trial;

        assign trial = r_r2[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (r_v2[g] >= trial) begin
                r_v2[g+1] <= r_v2[g] - trial;
                r_r2[g+1] <= (r_r2[g] >> 1) + BIT;
            end else begin
                r_v2[g+1] <= r_v2[g];
                r_r2[g+1] <= r_r2[g] >> 1;
            end
        end
    end

    // sigma * |z|.
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(r_sigma) * 64'(r_r2[gns_pkg::SQRT_STEPS][31:0]);
    end

    // Round from Q24, half away from zero, and apply the sign.
    logic [63:0]        n_rnd;
    logic signed [40:0] r_sz;

    assign n_rnd = r_prod + (64'd1 << (gns_pkg::ZQ - 1));

    always_ff @(posedge i_clk) begin
        if (r_sb[gns_pkg::IDX_RND - 1].neg) begin
            r_sz <= -$signed({1'b0, n_rnd[63:gns_pkg::ZQ]});
        end else begin
            r_sz <= $signed({1'b0, n_rnd[63:gns_pkg::ZQ]});
        end
    end

    // Final sum, saturation and the infinite tail.
    gns_pkg::t_side     w_sf;
    logic signed [42:0] n_sum;
    logic signed [42:0] w_max, w_min;

    assign w_sf  = r_sb[gns_pkg::DEPTH-1];
    assign w_max = 43'sd2147483647;
    assign w_min = -43'sd2147483648;
    assign n_sum = 43'($signed(w_sf.offset)) + 43'($signed(r_mean)) + 43'(r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[gns_pkg::DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_last_out <= w_sf.last;
        if (w_sf.tail) begin
            o_noisy_sample <= w_sf.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            o_saturated    <= 1'b1;
        end else if (n_sum > w_max) begin
            o_noisy_sample <= 32'sh7FFF_FFFF;
            o_saturated    <= 1'b1;
        end else if (n_sum < w_min) begin
            o_noisy_sample <= 32'sh8000_0000;
            o_saturated    <= 1'b1;
        end else begin
            o_noisy_sample <= n_sum[31:0];
            o_saturated    <= 1'b0;
        end
    end

endmodule

### design/gns_checker.sv
module gns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        i_last_in,
    input logic        o_valid,
    input logic signed [31:0] o_noisy_sample,
    input logic        o_saturated,
    input logic        o_last_out
);

    // The sampler never holds off a request.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    // Every result comes from a request a fixed latency earlier.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, gns_pkg::OUT_LAT))
        else $error("result without request");

    // The end-of-vector mark follows its request.
    a_last_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_out == $past(i_last_in, gns_pkg::OUT_LAT))
        else $error("last mark lost");

    // A clipped result sits at one end of the range.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_noisy_sample == 32'sh7FFF_FFFF || o_noisy_sample == 32'sh8000_0000))
        else $error("saturated value not at a limit");

endmodule

bind gaussian_noise_sampler_core gns_checker u_gns_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_last_in      (i_last_in),
    .o_valid        (o_valid),
    .o_noisy_sample (o_noisy_sample),
    .o_saturated    (o_saturated),
    .o_last_out     (o_last_out)
);
